// ----- hw/rtl/frie_pkg.sv -----
// ============================================================================
// frie_pkg: shared types and constants of the four-register executor
// Opcodes, serial ALU control and status, default parameter values and
// the bit layout of the stream payloads.
// ============================================================================
package frie_pkg;

  // Parameter defaults
  localparam int PROGRAM_LINES_DEF  = 128;
  localparam int REGISTER_COUNT_DEF = 4;
  localparam int DATA_WIDTH_DEF     = 32;

  // Fixed field widths
  localparam int OP_W      = 4;
  localparam int IMM_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam int JT_W      = 7;
  localparam int PC_OUT_W  = 8;

  // Input tdata layout (lowest bit first)
  localparam int IN_FIMM_FLAG_BIT = 0;
  localparam int IN_FIMM_LSB      = 1;
  localparam int IN_FREG_LSB      = 33;
  localparam int IN_SIMM_FLAG_BIT = 35;
  localparam int IN_SIMM_LSB      = 36;
  localparam int IN_SREG_LSB      = 68;
  localparam int IN_JT_LSB        = 70;
  localparam int IN_RV_LSB        = 77;
  localparam int IN_TDATA_W       = 112;

  // Output tdata layout (lowest bit first)
  localparam int OUT_PC_LSB   = 0;
  localparam int OUT_HALT_BIT = 8;
  localparam int OUT_PV_BIT   = 9;
  localparam int OUT_PVAL_LSB = 10;
  localparam int OUT_BT_BIT   = 42;
  localparam int OUT_DZ_BIT   = 43;
  localparam int OUT_TDATA_W  = 48;

  // Instruction opcodes; code 15 is unused and behaves as nop
  typedef enum logic [OP_W-1:0] {
    OP_NOP   = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_MOV   = 4'd5,
    OP_JMP   = 4'd6,
    OP_JE    = 4'd7,
    OP_JNE   = 4'd8,
    OP_JG    = 4'd9,
    OP_JGE   = 4'd10,
    OP_JL    = 4'd11,
    OP_JLE   = 4'd12,
    OP_READ  = 4'd13,
    OP_PRINT = 4'd14
  } op_t;

  // Serial ALU operations
  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_CMP,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic lt;
  } alu_sts_t;

endpackage

// ----- hw/rtl/frie_ram.sv -----
// ============================================================================
// frie_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module frie_ram #(
  parameter  int WIDTH = frie_pkg::DATA_WIDTH_DEF,
  parameter  int DEPTH = frie_pkg::REGISTER_COUNT_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/frie_alu.sv -----
// ============================================================================
// frie_alu: bit-serial arithmetic unit
// Add, subtract and compare one bit per cycle LSB first; multiply by
// shift-and-add and divide by restoring division, one bit per cycle.
// ============================================================================
module frie_alu #(
  parameter int DATA_WIDTH = frie_pkg::DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  frie_pkg::alu_ctl_t      ctl,
  input  logic [DATA_WIDTH-1:0]   x,
  input  logic [DATA_WIDTH-1:0]   y,
  output frie_pkg::alu_sts_t      sts,
  output logic [DATA_WIDTH-1:0]   result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {
    AL_IDLE,
    AL_RUN,
    AL_FIX
  } al_state_t;

  al_state_t               state_r;
  frie_pkg::alu_op_t       op_r;
  logic [DATA_WIDTH-1:0]   sx_r;
  logic [DATA_WIDTH-1:0]   sy_r;
  logic [DATA_WIDTH-1:0]   res_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    carry_r;
  logic                    nz_r;
  logic                    lt_r;
  logic                    qneg_r;

  logic                    div_in;
  logic [DATA_WIDTH-1:0]   x_load;
  logic [DATA_WIDTH-1:0]   y_load;
  logic                    inv;
  logic                    ybit;
  logic                    sbit;
  logic                    cout;
  logic [DATA_WIDTH:0]     trial;
  logic                    qbit;
  logic                    last;

  // Operand load: magnitudes for division
  assign div_in = (ctl.op == frie_pkg::ALU_DIV);
  assign x_load = (div_in && x[DATA_WIDTH-1]) ? (~x + DATA_WIDTH'(1)) : x;
  assign y_load = (div_in && y[DATA_WIDTH-1]) ? (~y + DATA_WIDTH'(1)) : y;

  // One-bit full adder for the serial add, subtract and compare
  assign inv  = (op_r == frie_pkg::ALU_SUB) || (op_r == frie_pkg::ALU_CMP);
  assign ybit = sy_r[0] ^ inv;
  assign sbit = sx_r[0] ^ ybit ^ carry_r;
  assign cout = (sx_r[0] & ybit) | (sx_r[0] & carry_r) | (ybit & carry_r);

  // Restoring division trial subtract
  assign trial = {res_r, sx_r[DATA_WIDTH-1]} - {1'b0, sy_r};
  assign qbit  = ~trial[DATA_WIDTH];

  assign last = (cnt_r == CNT_W'(DATA_WIDTH - 1));

  assign sts.done = (state_r == AL_FIX);
  assign sts.eq   = ~nz_r;
  assign sts.lt   = lt_r;
  assign result   = res_r;

  // Sequencer and shift registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
    end else begin
      case (state_r)
        AL_IDLE: begin
          if (ctl.start) begin
            state_r <= AL_RUN;
            op_r    <= ctl.op;
            cnt_r   <= '0;
            carry_r <= (ctl.op == frie_pkg::ALU_SUB) || (ctl.op == frie_pkg::ALU_CMP);
            nz_r    <= 1'b0;
            lt_r    <= 1'b0;
            qneg_r  <= div_in && (x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1]);
            sx_r    <= x_load;
            sy_r    <= y_load;
            res_r   <= '0;
          end
        end
        AL_RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (last) begin
            state_r <= AL_FIX;
          end
          case (op_r)
            frie_pkg::ALU_ADD, frie_pkg::ALU_SUB, frie_pkg::ALU_CMP: begin
              sx_r    <= sx_r >> 1;
              sy_r    <= sy_r >> 1;
              res_r   <= {sbit, res_r[DATA_WIDTH-1:1]};
              carry_r <= cout;
              nz_r    <= nz_r | sbit;
              // signed less-than from sign of difference and overflow
              if (last) begin
                lt_r <= sbit ^ (carry_r ^ cout);
              end
            end
            frie_pkg::ALU_MUL: begin
              if (sy_r[0]) begin
                res_r <= res_r + sx_r;
              end
              sx_r <= sx_r << 1;
              sy_r <= sy_r >> 1;
            end
            frie_pkg::ALU_DIV: begin
              if (qbit) begin
                res_r <= trial[DATA_WIDTH-1:0];
              end else begin
                res_r <= {res_r[DATA_WIDTH-2:0], sx_r[DATA_WIDTH-1]};
              end
              sx_r <= {sx_r[DATA_WIDTH-2:0], qbit};
            end
            default: begin
            end
          endcase
        end
        AL_FIX: begin
          // quotient sign fix-up
          if (op_r == frie_pkg::ALU_DIV) begin
            res_r <= qneg_r ? (~sx_r + DATA_WIDTH'(1)) : sx_r;
          end
          state_r <= AL_IDLE;
        end
        default: begin
          state_r <= AL_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/four_register_instruction_executor_top.sv -----
// ============================================================================
// four_register_instruction_executor_top: decoded-instruction executor
// Executes one decoded instruction per input transaction on a small signed
// register file and a program counter, and returns one result transaction
// with the next counter, halt, print, branch and divide-by-zero status.
// Add, sub, mul, div and the six compare-and-jumps run on the bit-serial
// ALU that retires one bit per cycle; nop, mov, jmp, read, print and a
// div with a zero divisor bypass it, and every transaction after the
// counter has reached PROGRAM_LINES only reports the counter without
// executing. Register operands are read one after the other from the
// single read port of the register RAM. The register file needs no
// clearing pass: per-entry valid bits make unwritten registers read as
// zero right after reset. A new transaction is taken while the previous
// result still waits in the output register.
// ============================================================================
module four_register_instruction_executor_top #(
  parameter int PROGRAM_LINES  = frie_pkg::PROGRAM_LINES_DEF,
  parameter int REGISTER_COUNT = frie_pkg::REGISTER_COUNT_DEF,
  parameter int DATA_WIDTH     = frie_pkg::DATA_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Instruction stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: first_is_imm, first_imm, first_reg, second_is_imm, second_imm,
  //        second_reg, jump_target, read_value, zero pad
  input  logic [frie_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: op
  input  logic [frie_pkg::OP_W-1:0]        in_tuser,
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: next_pc, halted, print_valid, print_value, branch_taken,
  //        div_by_zero, zero pad
  output logic [frie_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int PC_BITS = $clog2(PROGRAM_LINES + 1);
  localparam int PC_W    = (PC_BITS > frie_pkg::JT_W) ? PC_BITS : frie_pkg::JT_W;
  localparam int RAM_AW  = $clog2(REGISTER_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                          state_r;
  frie_pkg::op_t                   op_r;
  logic                            fimm_r;
  logic [frie_pkg::IMM_W-1:0]      fimmv_r;
  logic [frie_pkg::REG_IDX_W-1:0]  freg_r;
  logic                            simm_r;
  logic [frie_pkg::IMM_W-1:0]      simmv_r;
  logic [frie_pkg::REG_IDX_W-1:0]  sreg_r;
  logic [frie_pkg::JT_W-1:0]       jt_r;
  logic [frie_pkg::IMM_W-1:0]      rv_r;
  logic [DATA_WIDTH-1:0]           opa_r;
  logic                            dz_r;
  logic                            skip_r;
  logic                            rok_r;
  logic [PC_W-1:0]                 pc_r;
  logic [REGISTER_COUNT-1:0]       valid_r;
  logic                            out_tvalid_r;
  logic [frie_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic [frie_pkg::REG_IDX_W-1:0]  rd_idx;
  logic [RAM_AW-1:0]               ram_raddr;
  logic                            rd_ok;
  logic [DATA_WIDTH-1:0]           ram_rdata;
  logic [DATA_WIDTH-1:0]           rd_val;
  logic [DATA_WIDTH-1:0]           b_val;
  logic                            need_alu;
  frie_pkg::alu_op_t               alu_op;
  logic [DATA_WIDTH-1:0]           alu_x;
  logic [DATA_WIDTH-1:0]           alu_y;
  frie_pkg::alu_ctl_t              alu_ctl;
  frie_pkg::alu_sts_t              alu_sts;
  logic [DATA_WIDTH-1:0]           alu_res;
  logic                            fire;
  logic                            cond;
  logic                            taken;
  logic [PC_W-1:0]                 pc_nxt;
  logic                            pvalid;
  logic                            wr_sel;
  logic [frie_pkg::REG_IDX_W-1:0]  wr_idx;
  logic [DATA_WIDTH-1:0]           wr_data;
  logic                            wr_en;
  logic [RAM_AW-1:0]               ram_waddr;
  logic [frie_pkg::OUT_TDATA_W-1:0] out_tdata_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Register reads: first operand at accept, second operand in the next cycle (S_RDA)
  assign rd_idx    = (state_r == S_IDLE) ? in_tdata[frie_pkg::IN_FREG_LSB +: frie_pkg::REG_IDX_W]
                                         : sreg_r;
  assign ram_raddr = RAM_AW'(rd_idx);
  assign rd_ok     = (int'(rd_idx) < REGISTER_COUNT) && valid_r[ram_raddr];
  assign rd_val    = rok_r ? ram_rdata : '0;
  assign b_val     = simm_r ? DATA_WIDTH'(signed'(simmv_r)) : rd_val;

  frie_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REGISTER_COUNT)
  ) u_frie_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ram_waddr),
    .wdata (wr_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ALU dispatch while the second operand arrives
  always_comb begin
    need_alu = 1'b0;
    alu_op   = frie_pkg::ALU_ADD;
    alu_x    = rd_val;
    alu_y    = opa_r;
    case (op_r)
      frie_pkg::OP_ADD: begin
        need_alu = 1'b1;
      end
      frie_pkg::OP_SUB: begin
        need_alu = 1'b1;
        alu_op   = frie_pkg::ALU_SUB;
      end
      frie_pkg::OP_MUL: begin
        need_alu = 1'b1;
        alu_op   = frie_pkg::ALU_MUL;
      end
      frie_pkg::OP_DIV: begin
        // dst = src / dst; zero divisor skips the ALU
        need_alu = (rd_val != '0);
        alu_op   = frie_pkg::ALU_DIV;
        alu_x    = opa_r;
        alu_y    = rd_val;
      end
      frie_pkg::OP_JE, frie_pkg::OP_JNE, frie_pkg::OP_JG,
      frie_pkg::OP_JGE, frie_pkg::OP_JL, frie_pkg::OP_JLE: begin
        need_alu = 1'b1;
        alu_op   = frie_pkg::ALU_CMP;
        alu_x    = opa_r;
        alu_y    = b_val;
      end
      default: begin
      end
    endcase
  end

  assign alu_ctl.start = (state_r == S_RDB) && need_alu;
  assign alu_ctl.op    = alu_op;

  frie_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_frie_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .x      (alu_x),
    .y      (alu_y),
    .sts    (alu_sts),
    .result (alu_res)
  );

  // Branch condition from the compare flags
  always_comb begin
    case (op_r)
      frie_pkg::OP_JMP: cond = 1'b1;
      frie_pkg::OP_JE:  cond = alu_sts.eq;
      frie_pkg::OP_JNE: cond = ~alu_sts.eq;
      frie_pkg::OP_JG:  cond = ~alu_sts.lt & ~alu_sts.eq;
      frie_pkg::OP_JGE: cond = ~alu_sts.lt;
      frie_pkg::OP_JL:  cond = alu_sts.lt;
      frie_pkg::OP_JLE: cond = alu_sts.lt | alu_sts.eq;
      default:          cond = 1'b0;
    endcase
  end

  assign fire   = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
  assign taken  = ~skip_r & cond;
  assign pc_nxt = skip_r ? pc_r : (taken ? PC_W'(jt_r) : pc_r + PC_W'(1));
  assign pvalid = ~skip_r && (op_r == frie_pkg::OP_PRINT);

  // Write-back selection
  always_comb begin
    wr_sel  = 1'b0;
    wr_idx  = sreg_r;
    wr_data = alu_res;
    case (op_r)
      frie_pkg::OP_ADD, frie_pkg::OP_SUB, frie_pkg::OP_MUL: begin
        wr_sel = 1'b1;
      end
      frie_pkg::OP_DIV: begin
        wr_sel = ~dz_r;
      end
      frie_pkg::OP_MOV: begin
        wr_sel  = 1'b1;
        wr_data = opa_r;
      end
      frie_pkg::OP_READ: begin
        wr_sel  = 1'b1;
        wr_idx  = freg_r;
        wr_data = DATA_WIDTH'(signed'(rv_r));
      end
      default: begin
      end
    endcase
  end

  assign ram_waddr = RAM_AW'(wr_idx);
  assign wr_en     = fire && ~skip_r && wr_sel && (int'(wr_idx) < REGISTER_COUNT);

  // Result payload
  always_comb begin
    out_tdata_nxt = '0;
    out_tdata_nxt[frie_pkg::OUT_PC_LSB +: frie_pkg::PC_OUT_W] = frie_pkg::PC_OUT_W'(pc_nxt);
    out_tdata_nxt[frie_pkg::OUT_HALT_BIT] = (pc_nxt >= PC_W'(PROGRAM_LINES));
    out_tdata_nxt[frie_pkg::OUT_PV_BIT]   = pvalid;
    out_tdata_nxt[frie_pkg::OUT_PVAL_LSB +: frie_pkg::IMM_W] =
      pvalid ? frie_pkg::IMM_W'(opa_r) : '0;
    out_tdata_nxt[frie_pkg::OUT_BT_BIT]   = taken;
    out_tdata_nxt[frie_pkg::OUT_DZ_BIT]   = ~skip_r & dz_r;
  end

  // Sequencer, instruction latch and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      pc_r         <= '0;
      valid_r      <= '0;
      skip_r       <= 1'b0;
    end else begin
      rok_r <= rd_ok;
      // drain the output register unless a new result replaces it
      if (out_tvalid_r && out_tready && !fire) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= frie_pkg::op_t'(in_tuser);
            fimm_r  <= in_tdata[frie_pkg::IN_FIMM_FLAG_BIT];
            fimmv_r <= in_tdata[frie_pkg::IN_FIMM_LSB +: frie_pkg::IMM_W];
            freg_r  <= in_tdata[frie_pkg::IN_FREG_LSB +: frie_pkg::REG_IDX_W];
            simm_r  <= in_tdata[frie_pkg::IN_SIMM_FLAG_BIT];
            simmv_r <= in_tdata[frie_pkg::IN_SIMM_LSB +: frie_pkg::IMM_W];
            sreg_r  <= in_tdata[frie_pkg::IN_SREG_LSB +: frie_pkg::REG_IDX_W];
            jt_r    <= in_tdata[frie_pkg::IN_JT_LSB +: frie_pkg::JT_W];
            rv_r    <= in_tdata[frie_pkg::IN_RV_LSB +: frie_pkg::IMM_W];
            // halted: report the counter without executing
            if (pc_r >= PC_W'(PROGRAM_LINES)) begin
              skip_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              skip_r  <= 1'b0;
              state_r <= S_RDA;
            end
          end
        end
        S_RDA: begin
          opa_r   <= fimm_r ? DATA_WIDTH'(signed'(fimmv_r)) : rd_val;
          state_r <= S_RDB;
        end
        S_RDB: begin
          dz_r    <= (op_r == frie_pkg::OP_DIV) && (rd_val == '0);
          state_r <= need_alu ? S_WAIT : S_DONE;
        end
        S_WAIT: begin
          if (alu_sts.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= out_tdata_nxt;
            pc_r         <= pc_nxt;
            if (wr_en) begin
              valid_r[ram_waddr] <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/frie_checker.sv -----
// ============================================================================
// frie_checker: port-level assertions for the executor
// Watches the result stream and checks reset, stall, halt and flag rules.
// ============================================================================
module frie_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [frie_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                            last_halt_r;
  logic [frie_pkg::PC_OUT_W-1:0]   last_pc_r;

  // Track the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_halt_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      last_halt_r <= out_tdata[frie_pkg::OUT_HALT_BIT];
      last_pc_r   <= out_tdata[frie_pkg::OUT_PC_LSB +: frie_pkg::PC_OUT_W];
    end
  end

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Once halted, every later result repeats the counter with halt set
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && last_halt_r |->
      out_tdata[frie_pkg::OUT_HALT_BIT] &&
      (out_tdata[frie_pkg::OUT_PC_LSB +: frie_pkg::PC_OUT_W] == last_pc_r))
    else $error("halted executor moved its counter");

  // Print value is zero unless a print happened
  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[frie_pkg::OUT_PV_BIT] |->
      (out_tdata[frie_pkg::OUT_PVAL_LSB +: frie_pkg::IMM_W] == '0))
    else $error("print value without print");

  // A branch is never also a divide by zero or a print
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[frie_pkg::OUT_BT_BIT] |->
      !out_tdata[frie_pkg::OUT_DZ_BIT] && !out_tdata[frie_pkg::OUT_PV_BIT])
    else $error("branch flag with divide or print flag");

endmodule

bind four_register_instruction_executor_top frie_checker u_frie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/sv/tb_four_register_instruction_executor_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_four_register_instruction_executor_top: executor stream testbench
// Drives decoded instructions into the executor and checks every result against
// an in-bench register file and counter model or a typed row's written result.
// A short directed table covers operand extremes, each opcode, divide by
// zero, division overflow and the unused opcode. A long random run follows,
// with jumps that keep the counter inside the program. The run then ends by
// walking off the last line into the halted state.
// ============================================================================
module tb_four_register_instruction_executor_top;
  import frie_pkg::*;

  localparam int          PROG_LINES   = PROGRAM_LINES_DEF;
  localparam int          RAND_ITEMS   = 1200;
  localparam int          WDOG_LIMIT   = 4000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          MAX_PRINTS   = 40;
  localparam logic [3:0]  OP_UNUSED    = 4'hF;
  localparam logic [31:0] MAXV         = 32'h7FFF_FFFF;
  localparam logic [31:0] MINV         = 32'h8000_0000;
  localparam logic [31:0] ALL1         = 32'hFFFF_FFFF;

  // One decoded instruction
  typedef struct packed {
    logic [3:0]  op;
    logic        first_is_imm;
    logic [31:0] first_imm;
    logic [1:0]  first_reg;
    logic        second_is_imm;
    logic [31:0] second_imm;
    logic [1:0]  second_reg;
    logic [6:0]  jump_target;
    logic [31:0] read_value;
  } instr_t;

  // One execution result
  typedef struct packed {
    logic [7:0]  next_pc;
    logic        halted;
    logic        print_valid;
    logic [31:0] print_value;
    logic        branch_taken;
    logic        div_by_zero;
  } result_t;

  // Directed table row; typed rows carry a hand-written result
  typedef struct {
    instr_t  ins;
    logic    typed;
    result_t want;
  } row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Model state and scoreboard
  logic [31:0] regs [4];
  int          cur_pc;
  result_t     pending_q [$];
  row_t        dir_tbl [$];
  int          err_cnt     = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;

  four_register_instruction_executor_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Execute one instruction on the model state, return its result
  function automatic result_t execute_instr(input instr_t it);
    result_t     r;
    logic [31:0] a, b, d, an, dn, q;
    logic        cond;
    r    = '0;
    cond = 1'b0;
    if (cur_pc < PROG_LINES) begin
      a = it.first_is_imm  ? it.first_imm  : regs[it.first_reg];
      b = it.second_is_imm ? it.second_imm : regs[it.second_reg];
      d = regs[it.second_reg];
      cur_pc = cur_pc + 1;
      case (it.op)
        OP_ADD: regs[it.second_reg] = d + a;
        OP_SUB: regs[it.second_reg] = d - a;
        OP_MUL: regs[it.second_reg] = d * a;
        OP_DIV: begin
          if (d == '0) begin
            r.div_by_zero = 1'b1;
          end else begin
            // magnitudes, then sign; min / -1 wraps back to min
            an = a[31] ? -a : a;
            dn = d[31] ? -d : d;
            q  = an / dn;
            regs[it.second_reg] = (a[31] ^ d[31]) ? -q : q;
          end
        end
        OP_MOV:   regs[it.second_reg] = a;
        OP_JMP:   cond = 1'b1;
        OP_JE:    cond = (a == b);
        OP_JNE:   cond = (a != b);
        OP_JG:    cond = ($signed(a) >  $signed(b));
        OP_JGE:   cond = ($signed(a) >= $signed(b));
        OP_JL:    cond = ($signed(a) <  $signed(b));
        OP_JLE:   cond = ($signed(a) <= $signed(b));
        OP_READ:  regs[it.first_reg] = it.read_value;
        OP_PRINT: begin
          r.print_valid = 1'b1;
          r.print_value = a;
        end
        default: ;
      endcase
      if (cond) begin
        r.branch_taken = 1'b1;
        cur_pc = it.jump_target;
      end
    end
    r.next_pc = cur_pc[7:0];
    r.halted  = (cur_pc >= PROG_LINES);
    return r;
  endfunction

  function automatic instr_t mk_ins(input logic [3:0] op, input logic fi,
                                    input logic [31:0] fimm, input logic [1:0] freg,
                                    input logic si, input logic [31:0] simm,
                                    input logic [1:0] sreg, input logic [6:0] jt,
                                    input logic [31:0] rv);
    instr_t it;
    it = '{op, fi, fimm, freg, si, simm, sreg, jt, rv};
    return it;
  endfunction

  function automatic result_t mk_res(input logic [7:0] pc, input logic halted,
                                     input logic pv, input logic [31:0] pval,
                                     input logic bt, input logic dz);
    result_t r;
    r = '{pc, halted, pv, pval, bt, dz};
    return r;
  endfunction

  // Operand values biased toward the interesting corners
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return ALL1;
      3:       return MAXV;
      4:       return MINV;
      5, 6:    return $urandom_range(0, 32) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t rand_instr();
    instr_t it;
    it.op            = $urandom_range(0, 15);
    it.first_is_imm  = $urandom_range(0, 1);
    it.first_imm     = rand_word();
    it.first_reg     = $urandom_range(0, 3);
    it.second_is_imm = $urandom_range(0, 1);
    it.second_imm    = rand_word();
    it.second_reg    = $urandom_range(0, 3);
    it.jump_target   = $urandom_range(0, 127);
    it.read_value    = rand_word();
    // equal compare operands now and then
    if ($urandom_range(0, 3) == 0) begin
      it.second_is_imm = it.first_is_imm;
      it.second_imm    = it.first_imm;
      it.second_reg    = it.first_reg;
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_cnt < MAX_PRINTS)
      $display("ERROR @%0t: %s expected %0h got %0h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Present one instruction and hold it until accepted
  task automatic send_item(input instr_t it, input logic typed, input result_t want);
    result_t pred;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = it.op;
    in_tdata  = '0;
    in_tdata[IN_FIMM_FLAG_BIT]        = it.first_is_imm;
    in_tdata[IN_FIMM_LSB +: IMM_W]    = it.first_imm;
    in_tdata[IN_FREG_LSB +: REG_IDX_W] = it.first_reg;
    in_tdata[IN_SIMM_FLAG_BIT]        = it.second_is_imm;
    in_tdata[IN_SIMM_LSB +: IMM_W]    = it.second_imm;
    in_tdata[IN_SREG_LSB +: REG_IDX_W] = it.second_reg;
    in_tdata[IN_JT_LSB +: JT_W]       = it.jump_target;
    in_tdata[IN_RV_LSB +: IMM_W]      = it.read_value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = execute_instr(it);
    pending_q.push_back(typed ? want : pred);
  endtask

  // Sender bursts with random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Hold off the sender until every pending result is back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stall patterns
  initial begin
    int mode;
    int span;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = $urandom_range(0, 1);
          2:       out_tready = ($urandom_range(0, 7) == 0);
          default: out_tready = ((c % 12) >= 9);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.next_pc      = out_tdata[OUT_PC_LSB +: PC_OUT_W];
      got.halted       = out_tdata[OUT_HALT_BIT];
      got.print_valid  = out_tdata[OUT_PV_BIT];
      got.print_value  = out_tdata[OUT_PVAL_LSB +: IMM_W];
      got.branch_taken = out_tdata[OUT_BT_BIT];
      got.div_by_zero  = out_tdata[OUT_DZ_BIT];
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, next_pc", '0, got.next_pc);
      end else begin
        want = pending_q.pop_front();
        if (got.next_pc !== want.next_pc)
          report_mismatch("next_pc", want.next_pc, got.next_pc);
        if (got.halted !== want.halted)
          report_mismatch("halted", want.halted, got.halted);
        if (got.print_valid !== want.print_valid)
          report_mismatch("print_valid", want.print_valid, got.print_valid);
        if (got.print_value !== want.print_value)
          report_mismatch("print_value", want.print_value, got.print_value);
        if (got.branch_taken !== want.branch_taken)
          report_mismatch("branch_taken", want.branch_taken, got.branch_taken);
        if (got.div_by_zero !== want.div_by_zero)
          report_mismatch("div_by_zero", want.div_by_zero, got.div_by_zero);
      end
    end
  end

  // Watchdog: cycles with no transaction on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WDOG_LIMIT);
    $display("ERROR: no transaction for %0d cycles", WDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus
  initial begin
    instr_t it;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cur_pc    = 0;
    for (int i = 0; i < 4; i++) regs[i] = '0;

    // Directed: op, first imm?, first imm, first reg, second imm?, second imm,
    // second reg, jump target, read value
    dir_tbl.push_back('{mk_ins(OP_PRINT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_res(1, 0, 1, 0, 0, 0)});          // zero after reset
    dir_tbl.push_back('{mk_ins(OP_DIV, 1, 5, 0, 0, 0, 1, 0, 0), 1'b1,
                        mk_res(2, 0, 0, 0, 0, 1)});          // divide by zero
    dir_tbl.push_back('{mk_ins(OP_MOV, 1, MAXV, 0, 0, 0, 0, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_ADD, 1, 1, 0, 0, 0, 0, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_PRINT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_MOV, 1, ALL1, 0, 0, 0, 1, 0, 0), 1'b0, result_t'(0)});
    // most negative / -1
    dir_tbl.push_back('{mk_ins(OP_DIV, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_PRINT, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_READ, 0, 0, 2, 0, 0, 0, 0, ALL1), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_SUB, 1, MINV, 0, 0, 0, 2, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_MUL, 0, 0, 2, 0, 0, 2, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_DIV, 1, -32'sd7, 0, 0, 0, 2, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JMP, 0, 0, 0, 0, 0, 0, 127, 0), 1'b1,
                        mk_res(127, 0, 0, 0, 1, 0)});        // last line
    dir_tbl.push_back('{mk_ins(OP_JE, 1, 5, 0, 1, 5, 0, 3, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JNE, 0, 0, 0, 0, 0, 1, 100, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JG, 1, MAXV, 0, 1, MINV, 0, 85, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JGE, 0, 0, 2, 1, -32'sd7, 0, 10, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JL, 1, MINV, 0, 1, MAXV, 0, 42, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JLE, 1, 1, 0, 1, 0, 0, 97, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_NOP, 1, ALL1, 3, 1, ALL1, 3, 127, ALL1), 1'b0,
                        result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_UNUSED, 1, ALL1, 3, 1, ALL1, 3, 127, ALL1), 1'b0,
                        result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_PRINT, 1, ALL1, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_res(46, 0, 1, ALL1, 0, 0)});      // negative immediate
    dir_tbl.push_back('{mk_ins(OP_READ, 0, 0, 3, 0, 0, 0, 0, MINV), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_DIV, 0, 0, 3, 0, 0, 3, 0, 0), 1'b0, result_t'(0)});
    dir_tbl.push_back('{mk_ins(OP_JMP, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, result_t'(0)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].ins, dir_tbl[i].typed, dir_tbl[i].want);
      pace();
    end

    // Random run; near the end of the program force a jump to stay live
    for (int n = 0; n < RAND_ITEMS; n++) begin
      it = rand_instr();
      if (cur_pc >= PROG_LINES - 8) it.op = OP_JMP;
      send_item(it, 1'b0, result_t'(0));
      pace();
      if (n == RAND_ITEMS / 2) wait_drained();
    end
    wait_drained();

    // Walk off the last line, then keep sending while halted
    it = rand_instr();
    it.op          = OP_JMP;
    it.jump_target = PROG_LINES - 4;
    send_item(it, 1'b0, result_t'(0));
    repeat (12) begin
      it = rand_instr();
      if (cur_pc < PROG_LINES)
        while (it.op inside {[OP_JMP:OP_JLE]}) it.op = $urandom_range(0, 15);
      send_item(it, 1'b0, result_t'(0));
      pace();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- four_register_instruction_executor_top.f -----
hw/rtl/frie_pkg.sv
hw/rtl/frie_ram.sv
hw/rtl/frie_alu.sv
hw/rtl/four_register_instruction_executor_top.sv
hw/rtl/frie_checker.sv
tb/sv/tb_four_register_instruction_executor_top.sv
